// ===== hdl/rc4pk_pkg.sv =====
package rc4pk_pkg;

  localparam int BYTE_W    = 8;
  localparam int TBL_DEPTH = 256;
  localparam int TBL_AW    = 8;

  // Item kind codes
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Sequencer commands to the datapath, at most one step bit high per cycle
  typedef struct packed {
    logic sched_start;
    logic init_write;
    logic ksa_read_i;
    logic ksa_read_j;
    logic ksa_write_i;
    logic ksa_write_j;
    logic drv_read_n;
    logic drv_read_inner;
    logic drv_read_final;
    logic drv_write;
    logic sched_done;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
  } stat_t;

endpackage

// ===== hdl/rc4pk_ctrl.sv =====
module rc4pk_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  rc4pk_pkg::stat_t stat,
  output rc4pk_pkg::cmd_t  cmd,
  output logic           busy
);
  import rc4pk_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_KA   = 4'd2;
  localparam logic [3:0] S_KB   = 4'd3;
  localparam logic [3:0] S_KC   = 4'd4;
  localparam logic [3:0] S_KD   = 4'd5;
  localparam logic [3:0] S_DE   = 4'd6;
  localparam logic [3:0] S_DF   = 4'd7;
  localparam logic [3:0] S_DG   = 4'd8;
  localparam logic [3:0] S_DH   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (go) begin
          cmd.sched_start = 1'b1;
          state_next      = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_write = 1'b1;
        if (stat.idx_last) begin
          state_next = S_KA;
        end
      end
      S_KA: begin
        cmd.ksa_read_i = 1'b1;
        state_next     = S_KB;
      end
      S_KB: begin
        cmd.ksa_read_j = 1'b1;
        state_next     = S_KC;
      end
      S_KC: begin
        cmd.ksa_write_i = 1'b1;
        state_next      = S_KD;
      end
      S_KD: begin
        cmd.ksa_write_j = 1'b1;
        state_next      = stat.idx_last ? S_DE : S_KA;
      end
      S_DE: begin
        cmd.drv_read_n = 1'b1;
        state_next     = S_DF;
      end
      S_DF: begin
        cmd.drv_read_inner = 1'b1;
        state_next         = S_DG;
      end
      S_DG: begin
        cmd.drv_read_final = 1'b1;
        state_next         = S_DH;
      end
      S_DH: begin
        cmd.drv_write = 1'b1;
        if (stat.idx_last) begin
          cmd.sched_done = 1'b1;
          state_next     = S_IDLE;
        end else begin
          state_next = S_DE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hdl/rc4pk_dp.sv =====
module rc4pk_dp #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_accept,
  input  logic                               kind,
  input  logic [rc4pk_pkg::BYTE_W-1:0]       byte_value,
  input  logic                               buffer_start,
  input  rc4pk_pkg::cmd_t                    cmd,
  output rc4pk_pkg::stat_t                   stat,
  output logic                               dp_free,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rc4pk_pkg::BYTE_W-1:0]       result_byte
);
  import rc4pk_pkg::*;

  localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);

  // Key store
  logic [BYTE_W-1:0] key_mem [MAX_KEY_BYTES];
  logic [CNT_W-1:0]  key_count;
  logic [KEY_AW-1:0] k;
  logic [BYTE_W-1:0] key_q;
  logic              key_wr;

  assign key_wr = in_accept && (kind == KIND_KEY) &&
                  (key_count < CNT_W'(MAX_KEY_BYTES));

  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[key_count[KEY_AW-1:0]] <= byte_value;
    end
    if (cmd.ksa_read_i) begin
      key_q <= key_mem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (cmd.sched_done) begin
      key_count <= '0;
    end else if (key_wr) begin
      key_count <= key_count + CNT_W'(1);
    end
  end

  // Permutation and schedule registers
  logic [BYTE_W-1:0] perm_mem [TBL_DEPTH];
  logic [BYTE_W-1:0] perm_q;
  logic [TBL_AW-1:0] idx;
  logic [TBL_AW-1:0] idx_n;
  logic [TBL_AW-1:0] j;
  logic [TBL_AW-1:0] j_new;
  logic [BYTE_W-1:0] si;
  logic [BYTE_W-1:0] sn;
  logic              perm_rd;
  logic [TBL_AW-1:0] perm_rd_addr;
  logic              perm_wr;
  logic [TBL_AW-1:0] perm_wr_addr;
  logic [BYTE_W-1:0] perm_wr_data;

  assign idx_n = idx + TBL_AW'(1);
  assign j_new = j + perm_q + key_q;

  always_comb begin
    perm_rd      = 1'b1;
    perm_rd_addr = idx;
    priority if (cmd.ksa_read_j) begin
      perm_rd_addr = j_new;
    end else if (cmd.drv_read_n) begin
      perm_rd_addr = idx_n;
    end else if (cmd.drv_read_inner) begin
      perm_rd_addr = perm_q + idx_n;
    end else if (cmd.drv_read_final) begin
      perm_rd_addr = sn + perm_q;
    end else if (cmd.ksa_read_i) begin
      perm_rd_addr = idx;
    end else begin
      perm_rd = 1'b0;
    end
  end

  always_comb begin
    perm_wr      = cmd.init_write || cmd.ksa_write_i || cmd.ksa_write_j;
    perm_wr_addr = idx;
    perm_wr_data = idx;
    priority if (cmd.ksa_write_i) begin
      perm_wr_data = perm_q;
    end else if (cmd.ksa_write_j) begin
      perm_wr_addr = j;
      perm_wr_data = si;
    end else begin
      perm_wr_data = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (perm_wr) begin
      perm_mem[perm_wr_addr] <= perm_wr_data;
    end
    if (perm_rd) begin
      perm_q <= perm_mem[perm_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      j   <= '0;
      k   <= '0;
    end else if (cmd.sched_start) begin
      idx <= '0;
      j   <= '0;
      k   <= '0;
    end else begin
      if (cmd.init_write || cmd.ksa_write_j || cmd.drv_write) begin
        idx <= idx_n;
      end
      if (cmd.ksa_read_j) begin
        j <= j_new;
      end
      if (cmd.ksa_write_j) begin
        if (CNT_W'(k) + CNT_W'(1) >= key_count) begin
          k <= '0;
        end else begin
          k <= k + KEY_AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ksa_read_j) begin
      si <= perm_q;
    end
    if (cmd.drv_read_inner) begin
      sn <= perm_q;
    end
  end

  assign stat.idx_last = (idx == TBL_AW'(TBL_DEPTH - 1));

  // Keystream table; masked to zero at the output until the first schedule completes
  logic [BYTE_W-1:0] stream_mem [TBL_DEPTH];
  logic [BYTE_W-1:0] stream_q;
  logic              keyed;
  logic [TBL_AW-1:0] stream_position;
  logic [TBL_AW-1:0] pos_eff;
  logic              data_acc;

  assign data_acc = in_accept && (kind == KIND_DATA);
  assign pos_eff  = buffer_start ? '0 : stream_position;

  always_ff @(posedge clk) begin
    if (cmd.drv_write) begin
      stream_mem[idx] <= perm_q;
    end
    if (data_acc) begin
      stream_q <= stream_mem[pos_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keyed           <= 1'b0;
      stream_position <= '0;
    end else begin
      if (cmd.sched_done) begin
        keyed <= 1'b1;
      end
      if (data_acc) begin
        stream_position <= pos_eff + TBL_AW'(1);
      end
    end
  end

  // Read stage and output register
  logic              p_valid;
  logic              p_keyed;
  logic [BYTE_W-1:0] p_byte;
  logic              p_move;

  assign p_move  = p_valid && (!out_valid || out_ready);
  assign dp_free = !p_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (data_acc) begin
        p_valid <= 1'b1;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end
      if (p_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      p_byte  <= byte_value;
      p_keyed <= keyed;
    end
    if (p_move) begin
      result_byte <= p_byte ^ (p_keyed ? stream_q : '0);
    end
  end

endmodule

// ===== hdl/rc4_periodic_keystream_xor.sv =====
// Data item: read stage, then output register; one item per cycle while out_ready is high, sequencer idle.
// Key item: a key item flagged key_last then holds in_ready low through the permutation
//   fill, the key schedule (read i, read j, write i, write j) and the keystream build,
//   set by the single read and write port of the permutation memory.
// Reset (rst, synchronous): clears sequencer, key count, position and output valid;
//   the keystream reads as zero, so data passes unchanged until a key is scheduled.
module rc4_periodic_keystream_xor #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [rc4pk_pkg::BYTE_W-1:0] byte_value,
  input  logic                         key_last,
  input  logic                         buffer_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rc4pk_pkg::BYTE_W-1:0] result_byte
);
  import rc4pk_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy;
  logic  dp_free;
  logic  in_accept;
  logic  go;

  // Take items only when the sequencer is idle and the read stage can drain.
  assign in_ready  = !rst && !busy && dp_free;
  assign in_accept = in_valid && in_ready;

  // The final key byte is stored on the accepting edge if there is room, and kicks off the schedule either way.
  assign go = in_accept && (kind == KIND_KEY) && key_last;

  rc4pk_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  // Datapath: key store, permutation memory, keystream table and the
  // two-entry data path (read stage plus output register).
  rc4pk_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_accept    (in_accept),
    .kind         (kind),
    .byte_value   (byte_value),
    .buffer_start (buffer_start),
    .cmd          (cmd),
    .stat         (stat),
    .dp_free      (dp_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_byte  (result_byte)
  );

endmodule

// ===== hdl/rc4pk_checker.sv =====
module rc4pk_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       kind,
  input logic       key_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] result_byte
);
  import rc4pk_pkg::*;

  logic data_acc;
  logic sched_acc;

  assign data_acc  = in_valid && in_ready && (kind == KIND_DATA);
  assign sched_acc = in_valid && in_ready && (kind == KIND_KEY) && key_last;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_byte))
    else $error("result item changed while stalled");

  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(data_acc, 2))
    else $error("result item without a data item");

  a_data_delivers: assert property (@(posedge clk) disable iff (rst)
    data_acc && !out_valid |=> ##1 out_valid)
    else $error("data item did not reach the output");

  a_sched_busy: assert property (@(posedge clk) disable iff (rst)
    sched_acc |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken during key schedule");

endmodule

bind rc4_periodic_keystream_xor rc4pk_checker u_rc4pk_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .kind        (kind),
  .key_last    (key_last),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_byte (result_byte)
);

// ===== tb/sv/rc4_keystream_checker.sv =====
module rc4_keystream_checker
  import rc4pk_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              kind,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              key_last,
  input  logic              buffer_start,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [BYTE_W-1:0] result_byte,
  output int                mismatches,
  output int                results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [BYTE_W-1:0] byte_t;

  byte_t      key_bytes [TBL_DEPTH];
  logic [8:0] key_len;
  byte_t      perm [TBL_DEPTH];
  byte_t      keystream [TBL_DEPTH];
  byte_t      pos;
  byte_t      expected_bytes [$];

  always @(posedge clk) begin
    int unsigned j, k, len, n, sn, inner;
    byte_t swap, want;
    if (rst) begin
      key_len = '0;
      pos = '0;
      foreach (keystream[i]) keystream[i] = '0;
      expected_bytes.delete();
    end else begin
      // Compare first: a result never leaves in the cycle its item enters.
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          $display("%0t: result_byte expected none, actual %02h", $time, result_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (result_byte !== want) begin
            mismatches++;
            $display("%0t: result_byte expected %02h, actual %02h", $time, want, result_byte);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (kind == KIND_DATA) begin
          if (buffer_start) pos = '0;
          expected_bytes.push_back(byte_value ^ keystream[pos]);
          pos = pos + 1'b1;
        end else begin
          // Drop key bytes past capacity; a dropped final byte still schedules.
          if (key_len < MAX_KEY_BYTES) begin
            key_bytes[key_len[7:0]] = byte_value;
            key_len = key_len + 1'b1;
          end
          if (key_last) begin
            len = (key_len == 0) ? 1 : 32'(key_len);
            for (int i = 0; i < TBL_DEPTH; i++) perm[i] = byte_t'(i);
            j = 0;
            k = 0;
            for (int i = 0; i < TBL_DEPTH; i++) begin
              j = (j + perm[i] + key_bytes[k]) & 8'hFF;
              swap = perm[i];
              perm[i] = perm[j];
              perm[j] = swap;
              k++;
              if (k >= len) k = 0;
            end
            for (int i = 0; i < TBL_DEPTH; i++) begin
              n = (i + 1) & 8'hFF;
              sn = 32'(perm[n]);
              inner = 32'(perm[(sn + n) & 8'hFF]);
              keystream[i] = perm[(sn + inner) & 8'hFF];
            end
            key_len = '0;
          end
        end
      end
    end
    results_due <= expected_bytes.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rc4pk_pkg::*;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam int KEY_CAP        = 256;
  localparam int ITEM_TARGET    = 1100;
  // Long enough to back up the result path and hold the input off.
  localparam int STALL_CYCLES   = 600;
  // One full key schedule, so a late stray result still gets caught.
  localparam int DRAIN_CYCLES   = 2400;
  // Enough for every key schedule of the run plus worst-case gaps, taken many times over.
  localparam int TIMEOUT_CYCLES = 1_000_000;

  logic  clk          = 1'b0;
  logic  rst          = 1'b1;
  logic  in_valid     = 1'b0;
  logic  kind         = KIND_DATA;
  byte_t byte_value   = '0;
  logic  key_last     = 1'b0;
  logic  buffer_start = 1'b0;
  logic  out_ready    = 1'b0;
  logic  in_ready;
  logic  out_valid;
  byte_t result_byte;

  int mismatches;
  int results_due;
  int cycle_count    = 0;
  int stall_requests = 0;
  int items_sent     = 0;
  bit no_gaps        = 1'b0;

  always #1 clk = ~clk;

  rc4_periodic_keystream_xor #(
    .MAX_KEY_BYTES(KEY_CAP)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .byte_value  (byte_value),
    .key_last    (key_last),
    .buffer_start(buffer_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_byte (result_byte)
  );

  rc4_keystream_checker #(
    .MAX_KEY_BYTES(KEY_CAP)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .byte_value  (byte_value),
    .key_last    (key_last),
    .buffer_start(buffer_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_byte (result_byte),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random idle stretches, a changing idle rate (zero included),
  // and on request one long hold-off while the sender keeps pushing items.
  int rx_idle_left   = 0;
  int rx_stall_left  = 0;
  int rx_stalls_done = 0;
  int rx_idle_pct    = 20;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else if (stall_requests != rx_stalls_done) begin
      rx_stalls_done++;
      rx_stall_left = STALL_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_left > 0) begin
      out_ready <= 1'b0;
      rx_idle_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < rx_idle_pct) rx_idle_left = pick_gap();
      if ($urandom_range(0, 255) == 0) begin
        case ($urandom_range(0, 2))
          0: rx_idle_pct = 0;
          1: rx_idle_pct = 15;
          default: rx_idle_pct = 50;
        endcase
      end
    end
  end

  // Offer one item and hold it until the block takes it. An optional gap
  // goes in front, so valid never drops and rises in the same step.
  task automatic offer(input logic k, input byte_t v, input logic last, input logic start);
    if (!no_gaps && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    byte_value   <= v;
    key_last     <= last;
    buffer_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Key of len bytes, last one flagged; buffer_start is noise here.
  task automatic send_key(input int len);
    for (int i = 0; i < len; i++)
      offer(KIND_KEY, byte_t'($urandom_range(0, 255)), i == len - 1, 1'($urandom_range(0, 1)));
  endtask

  // Data run; key_last is noise here, and a position restart shows up now and then.
  task automatic send_data(input int count, input logic restart);
    for (int i = 0; i < count; i++)
      offer(KIND_DATA, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            (i == 0) ? restart : ($urandom_range(0, 99) < 3));
  endtask

  // Drop valid and hold until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    int klen;
    int round;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Before any key the keystream is zero: data must come back unchanged.
    offer(KIND_DATA, 8'h00, 1'b0, 1'b1);
    offer(KIND_DATA, 8'hFF, 1'b1, 1'b0);
    offer(KIND_DATA, 8'hA5, 1'b0, 1'b1);
    // One-byte all-zero key; buffer_start on a key byte must be ignored.
    offer(KIND_KEY, 8'h00, 1'b1, 1'b1);
    offer(KIND_DATA, 8'h00, 1'b0, 1'b1);
    offer(KIND_DATA, 8'hFF, 1'b1, 1'b0);
    offer(KIND_DATA, 8'h5A, 1'b0, 1'b0);
    offer(KIND_DATA, 8'h00, 1'b0, 1'b1);
    offer(KIND_DATA, 8'hFF, 1'b0, 1'b0);
    // Three-byte key with extreme values.
    offer(KIND_KEY, 8'hFF, 1'b0, 1'b0);
    offer(KIND_KEY, 8'h01, 1'b0, 1'b1);
    offer(KIND_KEY, 8'h80, 1'b1, 1'b0);
    offer(KIND_DATA, 8'hFF, 1'b0, 1'b0);
    offer(KIND_DATA, 8'h00, 1'b1, 1'b1);
    offer(KIND_DATA, 8'h01, 1'b0, 1'b0);
    offer(KIND_DATA, 8'h80, 1'b1, 1'b0);
    offer(KIND_DATA, 8'h7F, 1'b0, 1'b0);
    offer(KIND_DATA, 8'hFE, 1'b0, 1'b1);

    // Key lengths at and past capacity: exactly full, a dropped final byte
    // that still schedules, and a long run of dropped bytes.
    send_key(KEY_CAP);
    send_data(30, 1'b1);
    send_key(KEY_CAP + 1);
    send_data(30, 1'b0);
    send_key(KEY_CAP + 44);
    send_data(30, 1'b0);
    drain();

    // Random part: mostly well-formed key-then-data rounds, with stray key
    // bytes left dangling into the next key now and then.
    round = 0;
    while (items_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) klen = $urandom_range(1, 16);
      else if (r < 95) klen = $urandom_range(17, KEY_CAP);
      else klen = KEY_CAP;
      send_key(klen);
      if (round == 0) begin
        // Let the schedule finish, then hold the result side off while the
        // sender keeps offering back to back.
        no_gaps = 1'b1;
        send_data(5, 1'b1);
        stall_requests++;
        send_data(40, 1'b0);
      end else begin
        send_data($urandom_range(10, 80), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < $urandom_range(1, 3); i++)
          offer(KIND_KEY, byte_t'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        send_data($urandom_range(5, 20), 1'($urandom_range(0, 1)));
      end
      if (round == 4 || $urandom_range(0, 7) == 0) drain();
      round++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rc4pk_pkg.sv
hdl/rc4pk_ctrl.sv
hdl/rc4pk_dp.sv
hdl/rc4_periodic_keystream_xor.sv
hdl/rc4pk_checker.sv
tb/sv/rc4_keystream_checker.sv
tb/sv/tb_top.sv
